>>> rtl/core/dqsd_pkg.sv
// ----------------------------------------------------------------------------
// dqsd_pkg
// Shared sizes, operation and status codes, and the result record of the
// double-ended queue core.
// ----------------------------------------------------------------------------
package dqsd_pkg;

  localparam int CAPACITY   = 64;
  localparam int WORD_WIDTH = 32;
  localparam int PTR_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 7;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4,
    OP_READ       = 3'd5,
    OP_COUNT      = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic [FILL_W-1:0]  fill_level;
    status_e            status;
    logic [VALUE_W-1:0] result_value;
  } result_t;

endpackage

>>> rtl/core/dqsd_out_reg.sv
// ----------------------------------------------------------------------------
// dqsd_out_reg
// Output register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module dqsd_out_reg
  import dqsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  result_t push_data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    valid_q;
  result_t data_q;

  assign push_ready_o = !valid_q || ready_i;
  assign valid_o      = valid_q;
  assign data_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_valid_i && push_ready_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      data_q <= push_data_i;
    end
  end

endmodule

>>> rtl/core/deque_with_search_delete_core.sv
// ----------------------------------------------------------------------------
// deque_with_search_delete_core
// Bounded double-ended queue with delete-by-value, positional read and count.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; the next is accepted once the current
// result has moved into the output register. Push, pop and an out-of-range
// read answer straight from the idle state; an in-range read passes through
// S_READ for the memory read. Count, and a delete with no match, scan every
// entry. Delete scans up to the first match, then moves the later entries
// one place forward, one per cycle. A result held back by the sink delays
// the next transaction. The entry memory has one registered read port and
// one write port, and is walked one entry per cycle by a single comparator.
module deque_with_search_delete_core
  import dqsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], index[37:32], zero pad
  input  logic [2:0]  s_axis_tuser,  // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // result_value[31:0], status[34:32],
                                     // fill_level[41:35], zero pad
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [WORD_WIDTH-1:0] word_q, word_d;
  logic [PTR_W-1:0]      front_q, front_d;
  logic [CNT_W-1:0]      occ_q, occ_d;
  logic [CNT_W-1:0]      pos_q, pos_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [PTR_W-1:0]      cmp_pos_q, cmp_pos_d;
  logic                  wr_vld_q, wr_vld_d;
  logic [PTR_W-1:0]      wr_pos_q, wr_pos_d;
  result_t               res_q, res_d;

  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic [WORD_WIDTH-1:0] rdata_q;
  logic                  mem_we, mem_re;
  logic [PTR_W-1:0]      mem_waddr, mem_raddr;
  logic [WORD_WIDTH-1:0] mem_wdata;

  logic                  accept, hit, out_ready, out_valid;
  logic [FUNC_W-1:0]     in_func;
  logic [VALUE_W-1:0]    in_value;
  logic [INDEX_W-1:0]    in_index;
  result_t               out_data;

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W-1:0] pos);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= (PTR_W+1)'(CAPACITY)) begin
      sum = sum - (PTR_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign in_func  = s_axis_tuser[2:0];
  assign in_value = s_axis_tdata[31:0];
  assign in_index = s_axis_tdata[37:32];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign hit           = cmp_vld_q && (rdata_q == word_q);
  assign out_valid     = (state_q == S_RESP);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    word_d    = word_q;
    front_d   = front_q;
    occ_d     = occ_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    cmp_vld_d = 1'b0;
    cmp_pos_d = cmp_pos_q;
    wr_vld_d  = 1'b0;
    wr_pos_d  = wr_pos_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d               = op_e'(in_func);
          word_d             = in_value[WORD_WIDTH-1:0];
          res_d.result_value = '0;
          res_d.status       = STAT_OK;
          state_d            = S_RESP;
          case (op_e'(in_func))
            OP_PUSH_FRONT: begin
              if (occ_q == CNT_W'(CAPACITY)) begin
                res_d.status = STAT_FULL;
              end else begin
                front_d   = (front_q == '0) ? PTR_W'(CAPACITY - 1) : front_q - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = front_d;
                mem_wdata = in_value[WORD_WIDTH-1:0];
                occ_d     = occ_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (occ_q == CNT_W'(CAPACITY)) begin
                res_d.status = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(front_q, occ_q[PTR_W-1:0]);
                mem_wdata = in_value[WORD_WIDTH-1:0];
                occ_d     = occ_q + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (occ_q == '0) begin
                res_d.status = STAT_EMPTY;
              end else begin
                front_d = (front_q == PTR_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;
                occ_d   = occ_q - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (occ_q == '0) begin
                res_d.status = STAT_EMPTY;
              end else begin
                occ_d = occ_q - 1'b1;
              end
            end
            OP_DELETE, OP_COUNT: begin
              pos_d   = '0;
              cnt_d   = '0;
              state_d = S_SCAN;
            end
            OP_READ: begin
              if (CNT_W'(in_index) >= occ_q) begin
                res_d.status = STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(front_q, PTR_W'(in_index));
                state_d   = S_READ;
              end
            end
            default: begin
            end
          endcase
          res_d.fill_level = FILL_W'(occ_d);
        end
      end
      S_READ: begin
        res_d.result_value = VALUE_W'(rdata_q);
        state_d            = S_RESP;
      end
      S_SCAN: begin
        if (pos_q < occ_q) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(front_q, pos_q[PTR_W-1:0]);
          cmp_vld_d = 1'b1;
          cmp_pos_d = pos_q[PTR_W-1:0];
          pos_d     = pos_q + 1'b1;
        end
        if (op_q == OP_COUNT) begin
          if (hit) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (pos_q >= occ_q && !cmp_vld_q) begin
            res_d.result_value = VALUE_W'(cnt_q);
            state_d            = S_RESP;
          end
        end else if (hit) begin
          cmp_vld_d = 1'b0;
          pos_d     = CNT_W'(cmp_pos_q) + 1'b1;
          state_d   = S_SHIFT;
        end else if (pos_q >= occ_q && !cmp_vld_q) begin
          res_d.status = STAT_NOT_FOUND;
          state_d      = S_RESP;
        end
      end
      S_SHIFT: begin
        if (pos_q < occ_q) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(front_q, pos_q[PTR_W-1:0]);
          wr_vld_d  = 1'b1;
          wr_pos_d  = pos_q[PTR_W-1:0] - 1'b1;
          pos_d     = pos_q + 1'b1;
        end
        if (wr_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(front_q, wr_pos_q);
          mem_wdata = rdata_q;
        end
        if (pos_q >= occ_q && !wr_vld_q) begin
          occ_d            = occ_q - 1'b1;
          res_d.fill_level = FILL_W'(occ_q - 1'b1);
          state_d          = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_PUSH_FRONT;
      front_q   <= '0;
      occ_q     <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_pos_q <= '0;
      wr_vld_q  <= 1'b0;
      wr_pos_q  <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      front_q   <= front_d;
      occ_q     <= occ_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_pos_q <= cmp_pos_d;
      wr_vld_q  <= wr_vld_d;
      wr_pos_q  <= wr_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  dqsd_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (out_valid),
    .push_ready_o (out_ready),
    .push_data_i  (res_q),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .data_o       (out_data)
  );

  assign m_axis_tdata = {6'b0, out_data.fill_level, out_data.status,
                         out_data.result_value};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(front_q))
    else $error("front pointer moved without a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> (res_q.fill_level == FILL_W'(occ_q)))
    else $error("reported fill level differs from occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (pos_q <= occ_q) && (pos_q != '0))
    else $error("shift position out of range");

endmodule

>>> bench/deque_with_search_delete_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_delete_core_tb
// Stream-level test of the double-ended queue core. A shadow deque predicts
// the value/count, status and fill level of every command. Directed cases
// cover the empty and full queue. Random command mixes steer the fill level
// up and down, with random gaps on both sides, a long output hold-off and
// drain pauses.
// ----------------------------------------------------------------------------
module deque_with_search_delete_core_tb
  import dqsd_pkg::*;
();

  localparam logic [FUNC_W-1:0] OP_UNUSED = 3'd7;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // value[31:0], index[37:32], zero pad
  logic [2:0]  s_axis_tuser  = '0;  // func[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // result_value[31:0], status[34:32],
                                    // fill_level[41:35], zero pad

  logic [VALUE_W-1:0] shadow_deque[$];
  result_t            expected_results[$];
  int                 mismatch_count = 0;
  int                 tx_idle_max    = 11;
  int                 rx_idle_max    = 11;
  int                 rx_hold_cycles = 0;

  deque_with_search_delete_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("deque_with_search_delete_core test failed");
    $finish;
  end

  function automatic result_t deque_predict(logic [FUNC_W-1:0] func,
                                            logic [VALUE_W-1:0] word,
                                            logic [INDEX_W-1:0] pos);
    result_t r;
    int      hit;
    int      n;
    r        = '0;
    r.status = STAT_OK;
    case (func)
      OP_PUSH_FRONT: begin
        if (shadow_deque.size() >= CAPACITY) r.status = STAT_FULL;
        else shadow_deque.push_front(word);
      end
      OP_PUSH_BACK: begin
        if (shadow_deque.size() >= CAPACITY) r.status = STAT_FULL;
        else shadow_deque.push_back(word);
      end
      OP_POP_FRONT: begin
        if (shadow_deque.size() == 0) r.status = STAT_EMPTY;
        else void'(shadow_deque.pop_front());
      end
      OP_POP_BACK: begin
        if (shadow_deque.size() == 0) r.status = STAT_EMPTY;
        else void'(shadow_deque.pop_back());
      end
      OP_DELETE: begin
        hit = -1;
        for (int i = 0; i < shadow_deque.size() && hit < 0; i++)
          if (shadow_deque[i] == word) hit = i;
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else shadow_deque.delete(hit);
      end
      OP_READ: begin
        if (pos >= shadow_deque.size()) r.status = STAT_RANGE;
        else r.result_value = shadow_deque[pos];
      end
      OP_COUNT: begin
        n = 0;
        foreach (shadow_deque[i])
          if (shadow_deque[i] == word) n++;
        r.result_value = n;
      end
      default: ;
    endcase
    r.fill_level = FILL_W'(shadow_deque.size());
    return r;
  endfunction

  task automatic send_command(input logic [FUNC_W-1:0] func,
                              input logic [VALUE_W-1:0] word,
                              input logic [INDEX_W-1:0] pos);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, pos, word};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(deque_predict(func, word, pos));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // result receiver: random stalls plus an optional long hold-off
  initial begin
    int gap;
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = $urandom_range(0, rx_idle_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[31:0] !== want.result_value) begin
          $error("result_value: expected %0d, actual %0d",
                 $signed(want.result_value), $signed(m_axis_tdata[31:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[34:32] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tdata[34:32]);
          mismatch_count++;
        end
        if (m_axis_tdata[41:35] !== want.fill_level) begin
          $error("fill_level: expected %0d, actual %0d",
                 want.fill_level, m_axis_tdata[41:35]);
          mismatch_count++;
        end
      end
    end
  end

  // words: live entries, a few small values for duplicates, or anything
  function automatic logic [VALUE_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && shadow_deque.size() > 0)
      return shadow_deque[$urandom_range(0, shadow_deque.size() - 1)];
    if (r < 7) return $urandom_range(0, 7) - 4;
    return $urandom;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_pos();
    if (shadow_deque.size() > 0 && $urandom_range(0, 3) != 0)
      return INDEX_W'($urandom_range(0, shadow_deque.size() - 1));
    return INDEX_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(int push_pct);
    int r;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    r = $urandom_range(0, 19);
    if (r < 3)  return OP_POP_FRONT;
    if (r < 6)  return OP_POP_BACK;
    if (r < 10) return OP_DELETE;
    if (r < 15) return OP_READ;
    if (r < 19) return OP_COUNT;
    return OP_UNUSED;
  endfunction

  task automatic test_empty_queue();
    send_command(OP_POP_FRONT, 32'h1234_5678, 6'd0);
    send_command(OP_POP_BACK, 32'hFFFF_FFFF, 6'd63);
    send_command(OP_DELETE, 32'h0000_0000, 6'd0);
    send_command(OP_READ, 32'h0, 6'd0);
    send_command(OP_READ, 32'hFFFF_FFFF, 6'd63);
    send_command(OP_COUNT, 32'h0, 6'd0);
    send_command(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
    wait_results_drained();
  endtask

  task automatic test_directed_ops();
    send_command(OP_PUSH_FRONT, 32'h7FFF_FFFF, 6'd0);
    send_command(OP_PUSH_BACK, 32'h8000_0000, 6'd63);
    send_command(OP_PUSH_FRONT, 32'hFFFF_FFFF, 6'd0);
    send_command(OP_PUSH_BACK, 32'h0000_0000, 6'd0);
    send_command(OP_PUSH_BACK, 32'hFFFF_FFFF, 6'd0);
    send_command(OP_READ, 32'h0, 6'd0);
    send_command(OP_READ, 32'h0, 6'd1);
    send_command(OP_READ, 32'h0, 6'd4);
    send_command(OP_READ, 32'h0, 6'd5);
    send_command(OP_READ, 32'h0, 6'd63);
    send_command(OP_COUNT, 32'hFFFF_FFFF, 6'd0);
    send_command(OP_DELETE, 32'hFFFF_FFFF, 6'd0);
    send_command(OP_DELETE, 32'h8000_0000, 6'd0);
    send_command(OP_DELETE, 32'h5555_AAAA, 6'd0);
    send_command(OP_UNUSED, 32'h0, 6'd0);
    send_command(OP_POP_FRONT, 32'h0, 6'd0);
    send_command(OP_POP_BACK, 32'h0, 6'd0);
    send_command(OP_READ, 32'h0, 6'd0);
    wait_results_drained();
  endtask

  task automatic test_full_and_drain();
    while (shadow_deque.size() < CAPACITY)
      send_command($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                   pick_word(), pick_pos());
    send_command(OP_PUSH_FRONT, $urandom, 6'd0);
    send_command(OP_PUSH_BACK, $urandom, 6'd0);
    send_command(OP_READ, 32'h0, 6'd63);
    send_command(OP_COUNT, shadow_deque[10], 6'd0);
    send_command(OP_DELETE, shadow_deque[CAPACITY-1], 6'd0);
    send_command(OP_PUSH_BACK, shadow_deque[0], 6'd0);
    send_command(OP_DELETE, shadow_deque[0], 6'd0);
    send_command(OP_PUSH_FRONT, $urandom, 6'd0);
    while (shadow_deque.size() > 0)
      send_command($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom,
                   INDEX_W'($urandom));
    send_command(OP_POP_FRONT, 32'h0, 6'd0);
    wait_results_drained();
  endtask

  task automatic test_output_backpressure();
    tx_idle_max    = 0;
    rx_hold_cycles = 400;
    repeat (24) send_command(pick_func(60), pick_word(), pick_pos());
    wait_results_drained();
    tx_idle_max = 11;
  endtask

  task automatic test_random_mix(input int n, input int push_pct,
                                 input int tx_max, input int rx_max);
    tx_idle_max = tx_max;
    rx_idle_max = rx_max;
    repeat (n) send_command(pick_func(push_pct), pick_word(), pick_pos());
    wait_results_drained();
    tx_idle_max = 11;
    rx_idle_max = 11;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_directed_ops();
    test_full_and_drain();
    test_output_backpressure();
    test_random_mix(400, 50, 11, 11);
    test_random_mix(250, 75, 11, 11);
    test_random_mix(250, 25, 11, 11);
    test_random_mix(200, 55, 0, 0);
    test_random_mix(250, 62, 3, 11);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("deque_with_search_delete_core test passed");
    end else begin
      $display("deque_with_search_delete_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/dqsd_pkg.sv
rtl/core/dqsd_out_reg.sv
rtl/core/deque_with_search_delete_core.sv
bench/deque_with_search_delete_core_tb.sv
